// ===== rtl/core/mie_pkg.sv =====
// Package for the modular inverse block: widths, reset constants and the
// sequencer state type. No dependencies.
package mie_pkg;

   localparam int VALUE_BITS = 31;
   // Bezout coefficients stay within the modulus in magnitude; two extra bits
   // give the sign and headroom for partial sums.
   localparam int COEF_BITS  = VALUE_BITS + 2;
   // The divisor can be shifted left at most VALUE_BITS-1 places.
   localparam int SHIFT_BITS = $clog2(VALUE_BITS);

   localparam logic [VALUE_BITS-1:0] RESET_MODULUS = VALUE_BITS'(998244353);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_ALIGN,
      ST_REDUCE,
      ST_FIX
   } state_type;

endpackage

// ===== rtl/core/modular_inverse_euclid.sv =====
// Each Euclid step shifts the divisor left by the k places that its quotient
// needs and then reduces. The sum of k over all steps is at most 30 and there
// are at most about 46 steps. Throughput: one item at a time. A finished
// result waits in the output register while the next item is taken.
// Synchronous reset clears the sequencer and the output valid, and sets the
// modulus to 998244353.
// Top level of the modular inverse block; depends on mie_pkg.
module modular_inverse_euclid
   import mie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration: modulus.
   input  logic        csr_wen,
   input  logic [30:0] csr_wdata,
   // tdata: residue [30:0], zero [31].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // tdata: inverse [30:0], no_inverse [31], gcd_value [62:32], zero [63].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata
);

   state_type state_ff, state_in;

   logic [VALUE_BITS-1:0]       modulus_ff;
   logic [VALUE_BITS-1:0]       a_ff;
   logic [VALUE_BITS-1:0]       b_ff;
   logic signed [COEF_BITS-1:0] s0_ff;
   logic signed [COEF_BITS-1:0] s1_ff;
   logic signed [COEF_BITS-1:0] t_ff;
   logic [VALUE_BITS:0]         d_ff;
   logic [SHIFT_BITS-1:0]       k_ff;

   logic                  out_valid_ff;
   logic [VALUE_BITS-1:0] inv_ff;
   logic                  none_ff;
   logic [VALUE_BITS-1:0] gcd_ff;

   logic                        req_fire;
   logic                        out_free;
   logic                        load_out;
   logic [VALUE_BITS:0]         d_dbl;
   logic                        fits_dbl;
   logic                        fits;
   logic [VALUE_BITS:0]         rem_sub;
   logic signed [COEF_BITS-1:0] coef_sub;
   logic [VALUE_BITS-1:0]       r_next;
   logic signed [COEF_BITS-1:0] s_next;
   logic signed [COEF_BITS-1:0] mod_ext;
   logic signed [COEF_BITS-1:0] coef_up;
   logic signed [COEF_BITS-1:0] coef_down;
   logic signed [COEF_BITS-1:0] coef_norm;
   logic                        none_calc;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !out_valid_ff || rsp_tready;

   // Shared compare/subtract unit for the shift-subtract quotient.
   assign d_dbl    = {d_ff[VALUE_BITS-1:0], 1'b0};
   assign fits_dbl = !d_ff[VALUE_BITS] && (d_dbl <= {1'b0, a_ff});
   assign fits     = d_ff <= {1'b0, a_ff};
   assign rem_sub  = {1'b0, a_ff} - d_ff;
   assign coef_sub = s0_ff - t_ff;
   assign r_next   = fits ? rem_sub[VALUE_BITS-1:0] : a_ff;
   assign s_next   = fits ? coef_sub : s0_ff;

   // Final coefficient lies within one modulus of the target range.
   assign mod_ext   = $signed({2'b00, modulus_ff});
   assign coef_up   = s0_ff + mod_ext;
   assign coef_down = s0_ff - mod_ext;
   assign none_calc = (modulus_ff == '0) || (a_ff != VALUE_BITS'(1));

   always_comb begin
      if (s0_ff < 0) begin
         coef_norm = coef_up;
      end else if (s0_ff >= mod_ext) begin
         coef_norm = coef_down;
      end else begin
         coef_norm = s0_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_TEST;
         end
         ST_TEST: begin
            state_in = (b_ff == '0) ? ST_FIX : ST_ALIGN;
         end
         ST_ALIGN: begin
            if (!fits_dbl) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (k_ff == '0) state_in = ST_TEST;
         end
         ST_FIX: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_FIX:    load_out   = out_free;
         ST_TEST, ST_ALIGN, ST_REDUCE: begin
            req_tready = 1'b0;
         end
         default: begin
            req_tready = 1'b0;
            load_out   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         modulus_ff   <= RESET_MODULUS;
      end else begin
         state_ff <= state_in;
         if (csr_wen) modulus_ff <= csr_wdata;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Euclid datapath. Each step computes a mod b and s0 - q*s1 together, one
   // quotient bit per reduce cycle, then rotates the pairs.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               a_ff  <= req_tdata[VALUE_BITS-1:0];
               b_ff  <= modulus_ff;
               s0_ff <= COEF_BITS'(1);
               s1_ff <= '0;
            end
         end
         ST_TEST: begin
            d_ff <= {1'b0, b_ff};
            t_ff <= s1_ff;
            k_ff <= '0;
         end
         ST_ALIGN: begin
            if (fits_dbl) begin
               d_ff <= d_dbl;
               t_ff <= t_ff <<< 1;
               k_ff <= k_ff + SHIFT_BITS'(1);
            end
         end
         ST_REDUCE: begin
            if (k_ff == '0) begin
               a_ff  <= b_ff;
               b_ff  <= r_next;
               s0_ff <= s1_ff;
               s1_ff <= s_next;
            end else begin
               a_ff  <= r_next;
               s0_ff <= s_next;
               d_ff  <= d_ff >> 1;
               t_ff  <= t_ff >>> 1;
               k_ff  <= k_ff - SHIFT_BITS'(1);
            end
         end
         ST_FIX: begin
            if (load_out) begin
               gcd_ff  <= a_ff;
               none_ff <= none_calc;
               inv_ff  <= none_calc ? '0 : coef_norm[VALUE_BITS-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, gcd_ff, none_ff, inv_ff};

   // The block holds off new items while one is in work.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("input taken while an item is in work");

   // The running remainder stays below twice the divisor while reducing.
   a_reduce_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE) |-> ({2'b00, a_ff} < {d_ff, 1'b0}))
      else $error("quotient alignment lost");

   // An inverse is only reported with a unit gcd.
   a_unit_gcd: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[31]) |-> (rsp_tdata[62:32] == 31'd1))
      else $error("inverse reported with gcd other than one");

   a_zero_inv: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[31]) |-> (rsp_tdata[30:0] == '0))
      else $error("nonzero inverse with no_inverse set");

endmodule

// ===== tb/modular_inverse_euclid_tb.sv =====
// Self-checking testbench for modular_inverse_euclid: a scoreboard class predicts inverse,
// no-inverse flag and gcd per residue from its own extended Euclid model and modulus copy.
// Depends on mie_pkg and the modular_inverse_euclid RTL; needs nothing else.
module modular_inverse_euclid_tb
   import mie_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 4000;
   localparam int ITEMS_PER_MODULUS = 75;

   typedef logic [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      value_type inverse;
      logic      no_inverse;
      value_type gcd_value;
   } inverse_result_type;

   class inverse_scoreboard_type;
      value_type modulus;
      inverse_result_type pending_results[$];
      int unsigned errors;

      function new();
         modulus = RESET_MODULUS;
         errors = 0;
      endfunction

      function void set_modulus(value_type value);
         modulus = value;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      // Extended Euclid on (residue, modulus); only the residue's coefficient is tracked.
      function inverse_result_type predict_inverse(value_type residue);
         inverse_result_type res;
         longint a, b, m, q, rem, s_prev, s_cur, s_next;
         a = longint'(residue);
         m = longint'(modulus);
         b = m;
         s_prev = 1;
         s_cur = 0;
         while (b != 0) begin
            q = a / b;
            rem = a - q * b;
            s_next = s_prev - q * s_cur;
            a = b;
            b = rem;
            s_prev = s_cur;
            s_cur = s_next;
         end
         res.gcd_value = a[VALUE_BITS-1:0];
         res.no_inverse = 1'b1;
         res.inverse = '0;
         if (m != 0 && a == 1) begin
            s_prev = s_prev % m;
            if (s_prev < 0) begin
               s_prev += m;
            end
            res.inverse = s_prev[VALUE_BITS-1:0];
            res.no_inverse = 1'b0;
         end
         return res;
      endfunction

      function void note_residue(value_type residue);
         pending_results.push_back(predict_inverse(residue));
      endfunction

      function void check_result(logic [63:0] data);
         inverse_result_type want;
         inverse_result_type got;
         got.inverse = data[30:0];
         got.no_inverse = data[31];
         got.gcd_value = data[62:32];
         if (pending_results.size() == 0) begin
            $display("%0t: result with none pending: inverse %0d no_inverse %0d gcd %0d",
                     $time, got.inverse, got.no_inverse, got.gcd_value);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.inverse !== want.inverse) begin
            $display("%0t: inverse mismatch (modulus %0d): expected %0d, got %0d",
                     $time, modulus, want.inverse, got.inverse);
            errors++;
         end
         if (got.no_inverse !== want.no_inverse) begin
            $display("%0t: no_inverse mismatch (modulus %0d): expected %0d, got %0d",
                     $time, modulus, want.no_inverse, got.no_inverse);
            errors++;
         end
         if (got.gcd_value !== want.gcd_value) begin
            $display("%0t: gcd_value mismatch (modulus %0d): expected %0d, got %0d",
                     $time, modulus, want.gcd_value, got.gcd_value);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [30:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   int unsigned send_idle_pct = 36;
   int unsigned recv_idle_pct = 55;
   int unsigned quiet_cycles = 0;

   inverse_scoreboard_type sb = new();

   modular_inverse_euclid u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
      end
   end

   // Ends the run if neither channel moves an item for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, %0d results still pending", $time, sb.outstanding());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Called at a falling edge; returns at a falling edge with req_tvalid still high.
   task automatic send_residue(input value_type residue);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, residue};
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.note_residue(residue);
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_modulus(input value_type value);
      hold_until_drained();
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      sb.set_modulus(value);
      @(negedge clock);
   endtask

   function automatic value_type pick_modulus(int kind);
      value_type value;
      case (kind)
         0: begin
            value = value_type'($urandom);
            if (value < 2) begin
               value += 2;
            end
         end
         1: value = value_type'($urandom_range(2, 64));
         2: value = value_type'(1) << $urandom_range(1, 30);
         3: value = '1;
         4: value = value_type'(2);
         default: value = value_type'($urandom_range(2, 65535) * $urandom_range(1, 30000));
      endcase
      return value;
   endfunction

   // Mostly reduced residues; some are multiples of a small factor, some sit on
   // the edges, and the rest are unreduced full-width values.
   function automatic value_type pick_residue(value_type m);
      int unsigned roll;
      int unsigned factor;
      value_type value;
      roll = $urandom_range(0, 99);
      if (roll < 60 && m != 0) begin
         value = value_type'($urandom_range(0, m - 1));
      end else if (roll < 75) begin
         factor = $urandom_range(2, 16);
         value = value_type'(factor * $urandom_range(0, m / factor));
      end else if (roll < 85) begin
         case ($urandom_range(0, 4))
            0: value = '0;
            1: value = value_type'(1);
            2: value = m - 1;
            3: value = m;
            default: value = m + 1;
         endcase
      end else begin
         value = value_type'($urandom);
      end
      return value;
   endfunction

   initial begin
      value_type m;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset, all-ones and 12 moduli; edges of the residue, unreduced residues.
      send_residue('0);
      send_residue(value_type'(1));
      send_residue(value_type'(2));
      send_residue(value_type'(998244352));
      send_residue(value_type'(998244353));
      send_residue('1);
      send_residue(value_type'(31'h5555_5555));
      send_residue(value_type'(31'h2AAA_AAAA));
      write_modulus('1);
      send_residue(value_type'(1));
      send_residue(value_type'(31'h7FFF_FFFE));
      send_residue(value_type'(31'h4000_0000));
      send_residue(value_type'(31'h2AAA_AAAA));
      send_residue(value_type'(31'h5555_5555));
      write_modulus(value_type'(12));
      send_residue(value_type'(5));
      send_residue(value_type'(6));
      send_residue(value_type'(7));
      send_residue('0);
      send_residue(value_type'(11));
      // A modulus of one inverts everything to zero; a modulus of zero inverts nothing.
      write_modulus(value_type'(1));
      send_residue('0);
      send_residue(value_type'(5));
      write_modulus('0);
      send_residue(value_type'(7));
      send_residue('0);
      write_modulus(value_type'(2));
      send_residue(value_type'(1));

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 36;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            m = pick_modulus((phase * 4 + seg) % 6);
            write_modulus(m);
            for (int i = 0; i < ITEMS_PER_MODULUS; i++) begin
               if (seg == 0 && i == 40) begin
                  hold_until_drained();
               end
               send_residue(pick_residue(m));
            end
         end
      end

      hold_until_drained();
      repeat (300) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
      end
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
